// ----- sv/http_chunked_body_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Shorthand for clocked implication checks with a disable condition.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared widths, codes and the beat type passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

   localparam int SIZE_DIGITS_DEFAULT = 8;
   localparam int BYTE_W              = 8;
   localparam int KIND_W              = 2;
   localparam int COUNT_W             = 32;
   localparam int QUEUE_DEPTH         = 2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   // Character codes used by the classifier.
   localparam logic [BYTE_W-1:0] LF_CODE       = 8'd10;
   localparam logic [BYTE_W-1:0] DIGIT_OFFSET  = 8'd48;
   localparam logic [BYTE_W-1:0] UPPER_OFFSET  = 8'd55;
   localparam logic [BYTE_W-1:0] LOWER_OFFSET  = 8'd87;

   // One classified input beat.
   typedef struct packed {
      logic [BYTE_W-1:0] raw_byte;
      logic              is_hex;
      logic [3:0]        hex_val;
      logic              is_lf;
   } beat_type;

endpackage

`default_nettype wire

// ----- sv/hcbd_front.sv -----
// ----------------------------------------------------------------------------
// Chunked body decoder front end
// Accepts raw bytes and classifies them as hex digit, line feed or other.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_front (
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [hcbd_pkg::BYTE_W-1:0] req_raw_byte,
   input  wire logic                        queue_full,
   output logic                             push_valid,
   output hcbd_pkg::beat_type               push_beat
);
   import hcbd_pkg::*;

   logic [BYTE_W-1:0] digit_diff;
   logic [BYTE_W-1:0] upper_diff;
   logic [BYTE_W-1:0] lower_diff;

   // Offsets of the byte from each digit range base.
   assign digit_diff = req_raw_byte - DIGIT_OFFSET;
   assign upper_diff = req_raw_byte - UPPER_OFFSET;
   assign lower_diff = req_raw_byte - LOWER_OFFSET;

   // Classify the byte into the beat that goes into the queue.
   always_comb begin
      push_beat.raw_byte = req_raw_byte;
      push_beat.is_lf    = (req_raw_byte == LF_CODE);
      push_beat.is_hex   = 1'b1;
      push_beat.hex_val  = 4'd0;
      priority if (req_raw_byte >= 8'd48 && req_raw_byte <= 8'd57) begin
         push_beat.hex_val = digit_diff[3:0];
      end else if (req_raw_byte >= 8'd65 && req_raw_byte <= 8'd70) begin
         push_beat.hex_val = upper_diff[3:0];
      end else if (req_raw_byte >= 8'd97 && req_raw_byte <= 8'd102) begin
         push_beat.hex_val = lower_diff[3:0];
      end else begin
         push_beat.is_hex = 1'b0;
      end
   end

   // A beat is taken whenever the queue has room.
   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

endmodule

`default_nettype wire

// ----- sv/hcbd_queue.sv -----
// ----------------------------------------------------------------------------
// Chunked body decoder beat queue
// Short FIFO of classified beats between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire hcbd_pkg::beat_type push_beat,
   output logic                    queue_full,
   output logic                    pop_valid,
   input  wire logic               pop_take,
   output hcbd_pkg::beat_type      pop_beat
);
   import hcbd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   beat_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign queue_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_beat   = entries_ff[rd_ptr_ff];
   assign do_pop     = pop_take && pop_valid;

   // Pointer and fill count updates, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

`default_nettype wire

// ----- sv/hcbd_back.sv -----
// ----------------------------------------------------------------------------
// Chunked body decoder back end
// Runs the chunk framing state machine and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_back #(
   parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_wr_data,
   input  wire logic                        pop_valid,
   output logic                             pop_take,
   input  wire hcbd_pkg::beat_type          pop_beat,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [hcbd_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic [hcbd_pkg::KIND_W-1:0]      rsp_result_kind
);
   import hcbd_pkg::*;

   localparam int DIGIT_W = (SIZE_DIGITS > 1) ? $clog2(SIZE_DIGITS) : 1;

   typedef enum logic [6:0] {
      PH_FIRST    = 7'b0000001,
      PH_DIGITS   = 7'b0000010,
      PH_SKIPLINE = 7'b0000100,
      PH_DATA     = 7'b0001000,
      PH_TRAILER  = 7'b0010000,
      PH_FINAL    = 7'b0100000,
      PH_HALT     = 7'b1000000
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [COUNT_W-1:0]  remaining_ff, remaining_in;
   logic [DIGIT_W-1:0]  digit_ff, digit_in;
   logic [1:0]          discard_ff, discard_in;
   logic                mode_ff, mode_in;
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic [KIND_W-1:0]   out_kind_ff, out_kind_in;
   logic                out_free;
   logic                emit;
   logic [BYTE_W-1:0]   emit_byte;
   logic [KIND_W-1:0]   emit_kind;

   // A beat moves on when the result register is empty or being drained.
   assign out_free = !out_valid_ff || !rsp_stall;
   assign pop_take = pop_valid && out_free;

   // Framing state machine for one popped beat.
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      digit_in     = digit_ff;
      discard_in   = discard_ff;
      mode_in      = mode_ff;
      emit         = 1'b0;
      emit_byte    = '0;
      emit_kind    = KIND_DATA;

      if (csr_wr_en) begin
         // A mode write restarts the decoder.
         mode_in      = csr_wr_data;
         phase_in     = PH_FIRST;
         remaining_in = '0;
         digit_in     = '0;
         discard_in   = '0;
      end else if (pop_take) begin
         if (!mode_ff) begin
            emit      = 1'b1;
            emit_byte = pop_beat.raw_byte;
         end else begin
            unique case (phase_ff)
               PH_FIRST: begin
                  if (!pop_beat.is_hex) begin
                     phase_in  = PH_HALT;
                     emit      = 1'b1;
                     emit_kind = KIND_ERROR;
                  end else begin
                     remaining_in = COUNT_W'(pop_beat.hex_val);
                     digit_in     = '0;
                     phase_in     = PH_DIGITS;
                  end
               end
               PH_DIGITS: begin
                  if (pop_beat.is_hex) begin
                     if (digit_ff == DIGIT_W'(SIZE_DIGITS - 1)) begin
                        phase_in  = PH_HALT;
                        emit      = 1'b1;
                        emit_kind = KIND_ERROR;
                     end else begin
                        digit_in     = digit_ff + 1'b1;
                        remaining_in = {remaining_ff[COUNT_W-5:0], pop_beat.hex_val};
                     end
                  end else if (pop_beat.is_lf) begin
                     discard_in = 2'd2;
                     phase_in   = (remaining_ff == '0) ? PH_FINAL : PH_DATA;
                  end else begin
                     phase_in = PH_SKIPLINE;
                  end
               end
               PH_SKIPLINE: begin
                  if (pop_beat.is_lf) begin
                     discard_in = 2'd2;
                     phase_in   = (remaining_ff == '0) ? PH_FINAL : PH_DATA;
                  end
               end
               PH_DATA: begin
                  remaining_in = remaining_ff - 1'b1;
                  emit         = 1'b1;
                  emit_byte    = pop_beat.raw_byte;
                  if (remaining_ff == COUNT_W'(1)) begin
                     discard_in = 2'd2;
                     phase_in   = PH_TRAILER;
                  end
               end
               PH_TRAILER, PH_FINAL: begin
                  if (discard_ff > 2'd1) begin
                     discard_in = discard_ff - 1'b1;
                  end else begin
                     phase_in     = PH_FIRST;
                     remaining_in = '0;
                     digit_in     = '0;
                     discard_in   = '0;
                     if (phase_ff == PH_FINAL) begin
                        emit      = 1'b1;
                        emit_kind = KIND_END;
                     end
                  end
               end
               PH_HALT: begin
                  phase_in = PH_HALT;
               end
               default: begin
                  phase_in = PH_FIRST;
               end
            endcase
         end
      end
   end

   // Result register: load on an emitted result, clear once drained.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_kind_in  = out_kind_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_kind_in  = emit_kind;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         remaining_ff <= '0;
         digit_ff     <= '0;
         discard_ff   <= '0;
         mode_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         digit_ff     <= digit_in;
         discard_ff   <= discard_in;
         mode_ff      <= mode_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_kind_ff <= out_kind_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_result_kind  = out_kind_ff;

endmodule

`default_nettype wire

// ----- sv/http_chunked_body_decoder.sv -----
// A beat taken into an empty queue passes through its queue entry and then
// the result register before its result shows. Throughput: one beat per cycle;
// the back end handles one queued beat each cycle while the result register drains.
// Input stalls only when the two-entry beat queue is full.
// Reset: synchronous, clears the queue and result valid, sets mode to
// chunked and the framing state to expect a size digit.
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Front end classifies bytes, a beat queue decouples it from the framing
// back end, which emits payload, end and error results.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
   parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [hcbd_pkg::BYTE_W-1:0] req_raw_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [hcbd_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic [hcbd_pkg::KIND_W-1:0]      rsp_result_kind,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_wr_data
);
   import hcbd_pkg::*;

   logic     queue_full;
   logic     push_valid;
   beat_type push_beat;
   logic     pop_valid;
   logic     pop_take;
   beat_type pop_beat;

   // Byte classification.
   hcbd_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_raw_byte (req_raw_byte),
      .queue_full   (queue_full),
      .push_valid   (push_valid),
      .push_beat    (push_beat)
   );

   // Beat queue.
   hcbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_beat  (push_beat),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_beat   (pop_beat)
   );

   // Framing state machine and result register.
   hcbd_back #(
      .SIZE_DIGITS (SIZE_DIGITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .pop_valid        (pop_valid),
      .pop_take         (pop_take),
      .pop_beat         (pop_beat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_result_kind  (rsp_result_kind)
   );

endmodule

`default_nettype wire

// ----- sv/hcbd_checker.sv -----
// ----------------------------------------------------------------------------
// Chunked body decoder checker
// Port-level checks on both channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_chunked_body_decoder_macros.svh"

module hcbd_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic [hcbd_pkg::BYTE_W-1:0] req_raw_byte,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [hcbd_pkg::BYTE_W-1:0] rsp_payload_byte,
   input wire logic [hcbd_pkg::KIND_W-1:0] rsp_result_kind
);
   import hcbd_pkg::*;

   // A stalled result beat holds its payload.
   `HCBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_result_kind),
      "stalled result beat changed")

   // A stalled input beat stays offered with the same byte.
   `HCBD_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_raw_byte), "stalled input beat changed")

   // Only the three defined result kinds appear.
   `HCBD_ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_valid,
      rsp_result_kind == KIND_DATA || rsp_result_kind == KIND_END ||
      rsp_result_kind == KIND_ERROR, "undefined result kind")

   // End and error beats carry a zero byte.
   `HCBD_ASSERT_IMPLY(a_marker_zero, clock, reset,
      rsp_valid && rsp_result_kind != KIND_DATA, rsp_payload_byte == '0,
      "marker beat with nonzero byte")

   // No result is shown right after reset.
   `HCBD_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid,
      "result valid after reset")

endmodule

bind http_chunked_body_decoder hcbd_checker u_checker (.*);

`default_nettype wire

// ----- dv/tb_http_chunked_body_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the HTTP chunked body decoder
// Drives raw body bytes through the request channel and checks every result
// beat against a cycle-free model of the chunk framing kept in this file.
// Directed framing cases come first, then pass-through traffic, then
// randomized well-formed bodies mixed with malformed ones under several
// idling mixes, a long output hold-off and a mid-body pause.
// ----------------------------------------------------------------------------

module tb_http_chunked_body_decoder;
   import hcbd_pkg::*;

   localparam int SIZE_DIGITS_TB = SIZE_DIGITS_DEFAULT;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_LIMIT    = 5000;
   localparam logic [BYTE_W-1:0] CR_CODE = 8'h0D;

   // Framing states of the model.
   typedef enum logic [6:0] {
      AWAIT_FIRST = 7'b0000001,
      IN_DIGITS   = 7'b0000010,
      SKIP_TO_LF  = 7'b0000100,
      IN_DATA     = 7'b0001000,
      IN_TRAILER  = 7'b0010000,
      IN_FINAL    = 7'b0100000,
      HALTED      = 7'b1000000
   } frame_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [KIND_W-1:0] kind;
   } decoded_beat_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic [BYTE_W-1:0]    req_raw_byte = '0;
   logic                 rsp_stall    = 1'b0;
   logic                 csr_wr_en    = 1'b0;
   logic                 csr_wr_data  = 1'b0;
   wire                  req_stall;
   wire                  rsp_valid;
   wire  [BYTE_W-1:0]    rsp_payload_byte;
   wire  [KIND_W-1:0]    rsp_result_kind;

   // Model state.
   logic                 chunked_q = 1'b1;
   frame_state_type      frame_state = AWAIT_FIRST;
   logic [COUNT_W-1:0]   chunk_left = '0;
   logic [3:0]           digit_idx = '0;
   logic [1:0]           discard_cnt = '0;
   decoded_beat_type     pending_results[$];
   decoded_beat_type     oldest_result;

   // Stimulus control and bookkeeping.
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int bytes_sent = 0;
   int mode_writes = 0;
   int n_payload = 0;
   int n_end = 0;
   int n_error = 0;
   int input_stall_cycles = 0;
   int errors = 0;

   http_chunked_body_decoder #(
      .SIZE_DIGITS(SIZE_DIGITS_TB)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_byte     (req_raw_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_result_kind  (rsp_result_kind),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results still outstanding.", pending_results.size());
      $display("tb_http_chunked_body_decoder: done, errors");
      $finish;
   end

   // Value of a hex digit, or -1 for any other byte.
   function automatic int nibble_of(logic [BYTE_W-1:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
   endfunction

   function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] nib, bit upper);
      if (nib < 10) return "0" + nib;
      return 8'((upper ? "A" : "a") + nib - 10);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_non_hex(bit lf_ok);
      logic [BYTE_W-1:0] b;
      do b = 8'($urandom);
      while (nibble_of(b) >= 0 || (!lf_ok && b == LF_CODE));
      return b;
   endfunction

   function automatic void model_restart();
      frame_state = AWAIT_FIRST;
      chunk_left  = '0;
      digit_idx   = '0;
      discard_cnt = '0;
   endfunction

   function automatic void close_size_line();
      discard_cnt = 2'd2;
      frame_state = (chunk_left == 0) ? IN_FINAL : IN_DATA;
   endfunction

   // Advance the framing model by one accepted beat and queue any result.
   function automatic void predict_beat(logic [BYTE_W-1:0] c);
      int h;
      h = nibble_of(c);
      if (!chunked_q) begin
         pending_results.push_back('{c, KIND_DATA});
         return;
      end
      case (frame_state)
         AWAIT_FIRST: begin
            if (h < 0) begin
               frame_state = HALTED;
               pending_results.push_back('{8'd0, KIND_ERROR});
            end else begin
               chunk_left  = COUNT_W'(h);
               digit_idx   = '0;
               frame_state = IN_DIGITS;
            end
         end
         IN_DIGITS: begin
            if (h >= 0) begin
               if (int'(digit_idx) + 1 >= SIZE_DIGITS_TB) begin
                  frame_state = HALTED;
                  pending_results.push_back('{8'd0, KIND_ERROR});
               end else begin
                  digit_idx  = digit_idx + 1'b1;
                  chunk_left = {chunk_left[COUNT_W-5:0], 4'(h)};
               end
            end else if (c == LF_CODE) begin
               close_size_line();
            end else begin
               frame_state = SKIP_TO_LF;
            end
         end
         SKIP_TO_LF: begin
            if (c == LF_CODE) close_size_line();
         end
         IN_DATA: begin
            chunk_left = chunk_left - 1'b1;
            if (chunk_left == 0) begin
               discard_cnt = 2'd2;
               frame_state = IN_TRAILER;
            end
            pending_results.push_back('{c, KIND_DATA});
         end
         IN_TRAILER: begin
            if (discard_cnt > 1) discard_cnt = discard_cnt - 1'b1;
            else model_restart();
         end
         IN_FINAL: begin
            if (discard_cnt > 1) begin
               discard_cnt = discard_cnt - 1'b1;
            end else begin
               model_restart();
               pending_results.push_back('{8'd0, KIND_END});
            end
         end
         default: ;
      endcase
   endfunction

   // Predict on every accepted input beat and check every accepted result beat.
   always @(posedge clock) begin
      if (reset) begin
         chunked_q = 1'b1;
         model_restart();
      end else begin
         if (csr_wr_en) begin
            chunked_q = csr_wr_data;
            model_restart();
         end
         if (req_valid && req_stall === 1'b0) predict_beat(req_raw_byte);
         if (req_valid && req_stall === 1'b1) input_stall_cycles++;
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result beat, data %02h kind %0d", $time,
                        rsp_payload_byte, rsp_result_kind);
               errors++;
            end else begin
               oldest_result = pending_results.pop_front();
               if (rsp_payload_byte !== oldest_result.data) begin
                  $display("%0t: payload_byte expected %02h actual %02h", $time,
                           oldest_result.data, rsp_payload_byte);
                  errors++;
               end
               if (rsp_result_kind !== oldest_result.kind) begin
                  $display("%0t: result_kind expected %0d actual %0d", $time,
                           oldest_result.kind, rsp_result_kind);
                  errors++;
               end
               case (oldest_result.kind)
                  KIND_DATA: n_payload++;
                  KIND_END:  n_end++;
                  default:   n_error++;
               endcase
            end
         end
      end
   end

   // Result side back-pressure: random stalls, or a long hold-off on request.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one byte, with random idle cycles ahead of it, and wait for the beat.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid    <= 1'b0;
         req_raw_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_raw_byte <= b;
      do @(posedge clock);
      while (req_stall !== 1'b0);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Stop offering and wait until every predicted result has arrived.
   task automatic wait_for_quiet();
      int waited;
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  pending_results.size());
         errors++;
         pending_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mode write; it also restarts the framing, so only done with nothing in flight.
   task automatic write_mode(input logic value);
      wait_for_quiet();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      mode_writes++;
   endtask

   // Size line in random case with optional leading zeros and extension.
   task automatic send_size_line(input int unsigned size);
      int unsigned need;
      int unsigned total;
      logic [BYTE_W-1:0] b;
      need = 1;
      while (need < SIZE_DIGITS_TB && (size >> (4 * need)) != 0) need++;
      total = ($urandom_range(99) < 25) ? $urandom_range(SIZE_DIGITS_TB, need) : need;
      for (int unsigned i = total; i > 0; i--)
         send_byte(hex_char(4'(size >> (4 * (i - 1))), 1'($urandom_range(1))));
      if ($urandom_range(99) < 70) begin
         send_byte(LF_CODE);
      end else begin
         send_byte(pick_non_hex(1'b0));
         repeat ($urandom_range(6)) begin
            b = 8'($urandom);
            if (b == LF_CODE) b = ";";
            send_byte(b);
         end
         send_byte(LF_CODE);
      end
   endtask

   // The two bytes after data or after the zero size line are not checked.
   task automatic send_trailer();
      if ($urandom_range(99) < 80) begin
         send_byte(CR_CODE);
         send_byte(LF_CODE);
      end else begin
         repeat (2) send_byte(8'($urandom));
      end
   endtask

   task automatic send_chunk(input int unsigned size);
      send_size_line(size);
      repeat (size) send_byte(8'($urandom));
      send_trailer();
   endtask

   // A complete body: up to four data chunks, then the zero chunk.
   task automatic send_body();
      int pick;
      repeat ($urandom_range(4)) begin
         pick = $urandom_range(99);
         if (pick < 80)      send_chunk($urandom_range(12, 1));
         else if (pick < 95) send_chunk($urandom_range(60, 13));
         else                send_chunk($urandom_range(300, 200));
      end
      send_size_line(0);
      send_trailer();
   endtask

   // Malformed or cut-off input, then a restart through the mode register.
   task automatic send_broken();
      case ($urandom_range(3))
         0: send_byte(pick_non_hex(1'b1));
         1: repeat ($urandom_range(SIZE_DIGITS_TB + 3, SIZE_DIGITS_TB + 1))
               send_byte(hex_char(4'($urandom), 1'($urandom_range(1))));
         2: repeat ($urandom_range(30, 5)) send_byte(8'($urandom));
         default: begin
            send_size_line($urandom_range(40, 2));
            repeat ($urandom_range(1)) send_byte(8'($urandom));
         end
      endcase
      repeat ($urandom_range(3)) send_byte(8'($urandom));
      write_mode(1'b1);
   endtask

   // Framing corner cases, error exits and both mode values.
   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      // Extension after the digits, then a single 0xFF data byte.
      send_text("1;");
      send_byte(LF_CODE);
      send_byte(8'hFF);
      send_byte(CR_CODE);
      send_byte(LF_CODE);
      // Zero size written with the full digit count, LF right after digits.
      send_text("00000000");
      send_byte(LF_CODE);
      send_byte(CR_CODE);
      send_byte(LF_CODE);
      // No leading digit halts; the next byte is dropped.
      send_text("g");
      send_byte(8'h00);
      // Pass-through of the byte extremes.
      write_mode(1'b0);
      send_byte(8'h00);
      send_byte(8'hFF);
      // One digit too many.
      write_mode(1'b1);
      send_text("123456789");
      write_mode(1'b1);
   endtask

   task automatic test_pass_through();
      write_mode(1'b0);
      idle_pct  = 30;
      stall_pct = 30;
      repeat (120) send_byte(8'($urandom));
      send_body();
      write_mode(1'b1);
   endtask

   task automatic test_framed_traffic(input int idle, input int stall, input int budget);
      int start;
      start     = bytes_sent;
      idle_pct  = idle;
      stall_pct = stall;
      while (bytes_sent - start < budget) begin
         if ($urandom_range(99) < 85) send_body();
         else send_broken();
         if ($urandom_range(99) < 4) write_mode(1'b1);
      end
      wait_for_quiet();
   endtask

   // Hold the result side off while the sender keeps pushing a long chunk.
   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      hold_request = 60;
      send_chunk(32);
      send_size_line(0);
      send_trailer();
      wait_for_quiet();
   endtask

   // The sender pauses in the middle of a chunk until all results are back.
   task automatic test_pause_mid_body();
      idle_pct  = 14;
      stall_pct = 14;
      send_text("5");
      send_byte(LF_CODE);
      repeat (2) send_byte(8'($urandom));
      wait_for_quiet();
      repeat (3) send_byte(8'($urandom));
      send_trailer();
      send_text("0");
      send_byte(LF_CODE);
      send_trailer();
      wait_for_quiet();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_pass_through();
      test_framed_traffic(0, 0, 390);
      test_framed_traffic(48, 0, 390);
      test_framed_traffic(0, 48, 390);
      test_framed_traffic(14, 14, 390);
      test_backpressure();
      test_pause_mid_body();
      wait_for_quiet();

      $display("Sent %0d input beats over %0d mode writes; checked %0d payload,",
               bytes_sent, mode_writes, n_payload);
      $display("%0d end and %0d error results; input held off for %0d cycles.",
               n_end, n_error, input_stall_cycles);
      if (errors == 0) begin
         $display("tb_http_chunked_body_decoder: done, clean");
      end else begin
         $display("tb_http_chunked_body_decoder: done, errors");
      end
      $finish;
   end

endmodule

// ----- http_chunked_body_decoder.f -----
+incdir+sv
sv/hcbd_pkg.sv
sv/hcbd_front.sv
sv/hcbd_queue.sv
sv/hcbd_back.sv
sv/http_chunked_body_decoder.sv
sv/hcbd_checker.sv
dv/tb_http_chunked_body_decoder.sv
